// File: rtl/c2f_pkg.sv
`timescale 1ns / 1ps
package c2f_pkg;

  localparam int ACC_W   = 128;
  localparam int COF_W   = 65;
  localparam int INV_W   = 48;
  localparam int CNT_W   = 7;
  localparam int MUL_LAST = 31;
  localparam int DIV_LAST = 127;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;
  localparam logic [1:0] ROW_NONE = 2'd3;

  localparam logic [INV_W-2:0] INV_MAX = '1;

  typedef struct packed {
    logic              operation;
    logic [1:0]        row_index;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] frac_a;
    logic [15:0] frac_b;
    logic [15:0] frac_c;
    logic        singular;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic mul_go;
    logic div_go;
    logic clr;
    logic sub;
  } alu_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_ISSUE, S_WAIT, S_PUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_COF, PH_DET, PH_DIV, PH_CONV
  } phase_t;

  function automatic logic [1:0] inc3(logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [3:0] flat_idx(logic [1:0] r, logic [1:0] c);
    return 4'({2'b0, r} + {1'b0, r, 1'b0}) + {2'b0, c};
  endfunction

  function automatic logic [3:0] row_of(logic [3:0] k);
    logic [3:0] rc;
    case (k)
      4'd0: rc = {2'd0, 2'd0};
      4'd1: rc = {2'd0, 2'd1};
      4'd2: rc = {2'd0, 2'd2};
      4'd3: rc = {2'd1, 2'd0};
      4'd4: rc = {2'd1, 2'd1};
      4'd5: rc = {2'd1, 2'd2};
      4'd6: rc = {2'd2, 2'd0};
      4'd7: rc = {2'd2, 2'd1};
      4'd8: rc = {2'd2, 2'd2};
      default: rc = '0;
    endcase
    return rc;
  endfunction

  // lattice entry for one factor of a 2x2 minor term
  function automatic logic [3:0] cof_lat_idx(logic [3:0] k, logic t, logic second);
    logic [3:0] rc;
    logic [1:0] a1, a2, b1, b2, r, c;
    rc = row_of(k);
    a1 = inc3(rc[3:2]);
    a2 = inc3(a1);
    b1 = inc3(rc[1:0]);
    b2 = inc3(b1);
    r = second ? a2 : a1;
    c = second ? (t ? b1 : b2) : (t ? b2 : b1);
    return flat_idx(r, c);
  endfunction

  function automatic logic [3:0] tr_idx(logic [3:0] k);
    logic [3:0] rc;
    rc = row_of(k);
    return flat_idx(rc[1:0], rc[3:2]);
  endfunction

endpackage

// File: rtl/cartesian_to_fractional_coords_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_item  (in_item_t)
// out     | output    | out_valid/out_stall | out_item (out_item_t)
// A convert runs nine shift-add products on one shared adder; the first
// convert after a load first inverts the lattice (18 + 3 products and nine
// divides).
// rst is synchronous and clears control state; it also clears the lattice to zero.
// The next item is taken while a result waits on a stalled output register.
module cartesian_to_fractional_coords_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  c2f_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output c2f_pkg::out_item_t out_item
);
  import c2f_pkg::*;

  localparam int DIV_SH = COORD_FRAC_BITS + 32;
  localparam int FR_LO  = COORD_FRAC_BITS + 16;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [3:0] k, k_next;
  logic [1:0] t, t_next;

  logic [31:0]      lat  [9];
  logic [COF_W-1:0] cof  [9];
  logic [INV_W-1:0] inv  [9];
  logic [31:0]      vin  [3];
  logic [15:0]      frac [3];
  logic             last_r, inv_valid, sing, dneg, qneg;
  logic [ACC_W-1:0] opa_r, dmag, acc;
  logic             busy;
  alu_cmd_t         cmd;
  logic [31:0]      mplier;
  logic             in_acc, out_acc;
  logic [COF_W-1:0] cof_rd;
  logic [ACC_W-1:0] cof_x, acc_abs;
  logic [INV_W-2:0] q_sat;
  logic [3:0]       wbase;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  c2f_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opa    (opa_r),
    .mplier (mplier),
    .den    (dmag),
    .busy   (busy),
    .acc    (acc)
  );

  always_comb begin
    cof_rd  = cof[tr_idx(k)];
    cof_x   = {{(ACC_W-COF_W){cof_rd[COF_W-1]}}, cof_rd};
    acc_abs = acc[ACC_W-1] ? -acc : acc;
    q_sat   = (acc > ACC_W'(INV_MAX)) ? INV_MAX : acc[INV_W-2:0];
    wbase   = flat_idx(in_item.row_index, 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_COF;
      k     <= '0;
      t     <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      k     <= k_next;
      t     <= t_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    k_next     = k;
    t_next     = t;
    cmd        = '0;
    mplier     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_item.operation == OP_CONVERT) begin
          k_next = '0;
          t_next = '0;
          if (!inv_valid) begin
            phase_next = PH_COF;
            state_next = S_FETCH;
          end else if (sing) begin
            state_next = S_PUSH;
          end else begin
            phase_next = PH_CONV;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.clr    = (t == 2'd0);
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        state_next = S_WAIT;
        unique case (phase)
          PH_COF: begin
            cmd.mul_go = 1'b1;
            cmd.sub    = t[0];
            mplier     = lat[cof_lat_idx(k, t[0], 1'b1)];
          end
          PH_DET: begin
            cmd.mul_go = 1'b1;
            mplier     = lat[{2'b0, t}];
          end
          PH_DIV: cmd.div_go = 1'b1;
          PH_CONV: begin
            cmd.mul_go = 1'b1;
            mplier     = vin[t];
          end
          default: ;
        endcase
      end
      S_WAIT: begin
        if (!busy) begin
          state_next = S_FETCH;
          unique case (phase)
            PH_COF: begin
              if (t == 2'd0) begin
                t_next = 2'd1;
              end else begin
                t_next = '0;
                if (k == 4'd8) begin
                  k_next     = '0;
                  phase_next = PH_DET;
                end else begin
                  k_next = k + 4'd1;
                end
              end
            end
            PH_DET: begin
              if (t != 2'd2) begin
                t_next = t + 2'd1;
              end else begin
                t_next = '0;
                k_next = '0;
                if (acc == '0) state_next = S_PUSH;
                else phase_next = PH_DIV;
              end
            end
            PH_DIV: begin
              if (k == 4'd8) begin
                k_next     = '0;
                phase_next = PH_CONV;
              end else begin
                k_next = k + 4'd1;
              end
            end
            PH_CONV: begin
              if (t != 2'd2) begin
                t_next = t + 2'd1;
              end else begin
                t_next = '0;
                if (k == 4'd2) state_next = S_PUSH;
                else k_next = k + 4'd1;
              end
            end
            default: ;
          endcase
        end
      end
      S_PUSH: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
      sing      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc && in_item.operation == OP_LOAD && in_item.row_index != ROW_NONE)
        inv_valid <= 1'b0;
      if (state == S_WAIT && !busy && phase == PH_DET && t == 2'd2 && acc == '0) begin
        inv_valid <= 1'b1;
        sing      <= 1'b1;
      end
      if (state == S_WAIT && !busy && phase == PH_DIV && k == 4'd8) begin
        inv_valid <= 1'b1;
        sing      <= 1'b0;
      end
      if (state == S_PUSH && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
    end
  end

  // rst clears the lattice to zero so a convert before any load reports singular
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) lat[i] <= '0;
    end else if (in_acc && in_item.operation == OP_LOAD && in_item.row_index != ROW_NONE) begin
      lat[wbase]        <= in_item.value_x;
      lat[wbase + 4'd1] <= in_item.value_y;
      lat[wbase + 4'd2] <= in_item.value_z;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_item.operation == OP_CONVERT) begin
      vin[0] <= in_item.value_x;
      vin[1] <= in_item.value_y;
      vin[2] <= in_item.value_z;
      last_r <= in_item.last_in;
      if (inv_valid && sing) begin
        for (int i = 0; i < 3; i++) frac[i] <= '0;
      end
    end
    if (state == S_FETCH) begin
      case (phase)
        PH_COF: begin
          opa_r <= {{(ACC_W-32){lat[cof_lat_idx(k, t[0], 1'b0)][31]}},
                    lat[cof_lat_idx(k, t[0], 1'b0)]};
        end
        PH_DET: opa_r <= {{(ACC_W-COF_W){cof[{2'b0, t}][COF_W-1]}}, cof[{2'b0, t}]};
        PH_DIV: begin
          qneg  <= cof_rd[COF_W-1] ^ dneg;
          opa_r <= (cof_rd[COF_W-1] ? -cof_x : cof_x) << DIV_SH;
        end
        default: begin
          opa_r <= {{(ACC_W-INV_W){inv[flat_idx(t, k[1:0])][INV_W-1]}},
                    inv[flat_idx(t, k[1:0])]};
        end
      endcase
    end
    if (state == S_WAIT && !busy) begin
      case (phase)
        PH_COF: if (t != 2'd0) cof[k] <= acc[COF_W-1:0];
        PH_DET: begin
          if (t == 2'd2) begin
            dneg <= acc[ACC_W-1];
            dmag <= acc_abs;
            if (acc == '0) begin
              for (int i = 0; i < 3; i++) frac[i] <= '0;
            end
          end
        end
        PH_DIV: inv[k] <= qneg ? -{1'b0, q_sat} : {1'b0, q_sat};
        default: if (t == 2'd2) frac[k[1:0]] <= acc[FR_LO+15:FR_LO];
      endcase
    end
    if (state == S_PUSH && (!out_valid || !out_stall)) begin
      out_item.frac_a   <= frac[0];
      out_item.frac_b   <= frac[1];
      out_item.frac_c   <= frac[2];
      out_item.singular <= sing;
      out_item.last_out <= last_r;
    end
  end

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.singular) |->
      (out_item.frac_a == '0 && out_item.frac_b == '0 && out_item.frac_c == '0))
    else $error("singular result with nonzero fractions");
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.operation == OP_CONVERT) |=> (state != S_IDLE))
    else $error("convert transaction did not start work");
  a_load_inval: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.operation == OP_LOAD && in_item.row_index != ROW_NONE) |=> !inv_valid)
    else $error("load kept a stale inverse");
`endif

endmodule

// File: rtl/c2f_alu.sv
`timescale 1ns / 1ps
module c2f_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  c2f_pkg::alu_cmd_t         cmd,
  input  logic [c2f_pkg::ACC_W-1:0] opa,
  input  logic [31:0]               mplier,
  input  logic [c2f_pkg::ACC_W-1:0] den,
  output logic                      busy,
  output logic [c2f_pkg::ACC_W-1:0] acc
);
  import c2f_pkg::*;

  logic [ACC_W-1:0] mc, den_r, rem;
  logic [31:0]      mp;
  logic [CNT_W-1:0] cnt;
  logic             div_mode, sub_r;
  logic [ACC_W-1:0] op_a, op_b;
  logic             do_sub, last_mul;
  logic [ACC_W:0]   sum;

  // one shared adder: shift-add multiply or restoring divide step
  always_comb begin
    last_mul = (cnt == CNT_W'(MUL_LAST));
    if (div_mode) begin
      op_a   = {rem[ACC_W-2:0], mc[ACC_W-1]};
      op_b   = den_r;
      do_sub = 1'b1;
    end else begin
      op_a   = acc;
      op_b   = mp[0] ? mc : '0;
      do_sub = sub_r ^ last_mul;
    end
    sum = {1'b0, op_a} + {1'b0, (do_sub ? ~op_b : op_b)} + {{ACC_W{1'b0}}, do_sub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.mul_go) begin
      busy <= 1'b1;
    end else if (cmd.div_go) begin
      busy <= 1'b1;
    end else if (busy) begin
      busy <= div_mode ? (cnt != CNT_W'(DIV_LAST)) : !last_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mc       <= opa;
      mp       <= mplier;
      cnt      <= '0;
      div_mode <= 1'b0;
      sub_r    <= cmd.sub;
    end else if (cmd.div_go) begin
      mc       <= opa;
      den_r    <= den;
      rem      <= '0;
      acc      <= '0;
      cnt      <= '0;
      div_mode <= 1'b1;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      mc  <= mc << 1;
      if (div_mode) begin
        rem <= sum[ACC_W] ? sum[ACC_W-1:0] : op_a;
        acc <= {acc[ACC_W-2:0], sum[ACC_W]};
      end else begin
        acc <= sum[ACC_W-1:0];
        mp  <= mp >> 1;
      end
    end else if (cmd.clr) begin
      acc <= '0;
    end
  end

`ifndef SYNTHESIS
  a_one_go: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_go && cmd.div_go)) else $error("mul and div started together");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_go || cmd.div_go) |-> !busy) else $error("start while busy");
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_go || cmd.div_go) |=> busy) else $error("start did not raise busy");
`endif

endmodule
